[rtl/til_pkg.sv]
`default_nettype none
package til_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOB     = 2'd1,
        ST_UNTILED = 2'd2
    } t_status;

    // Configuration register indexes
    localparam logic [2:0] REG_FIRST_LOW     = 3'd0;
    localparam logic [2:0] REG_FIRST_HIGH    = 3'd1;
    localparam logic [2:0] REG_FIRST_EXTENT  = 3'd2;
    localparam logic [2:0] REG_SECOND_LOW    = 3'd3;
    localparam logic [2:0] REG_SECOND_HIGH   = 3'd4;
    localparam logic [2:0] REG_SECOND_EXTENT = 3'd5;
    localparam logic [2:0] REG_ORDER_MODE    = 3'd6;

    // Divider lanes: two coordinates and the stride
    localparam int NLANES    = 3;
    localparam int LANE_C0   = 0;
    localparam int LANE_C1   = 1;
    localparam int LANE_STR  = 2;

    localparam int TILE_BITS = 64;

endpackage
`default_nettype wire

[rtl/tile_index_linearizer.sv]
`default_nettype none
// Tile index linearizer. One request (a cell coordinate pair) is taken in every
// clock cycle; busy stays low. Each request yields exactly one result, shown
// for one cycle with o_valid high. The request passes COORD_BITS + 5
// registers: an input stage, the bit-per-stage restoring dividers
// (COORD_BITS + 2 stages) that form the partition numbers and the stride, a
// partial-product stage, and the output register that holds the final add.
// The receiver cannot stall the block, so results must be taken as they
// appear. Configuration registers must be written only while no request is in
// flight; strides are derived from them inside the pipeline, so a request may
// follow a write directly.
module tile_index_linearizer #(
    parameter int DIMS       = 2,
    parameter int COORD_BITS = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  [COORD_BITS-1:0]         i_coord_first,
    input  wire  [COORD_BITS-1:0]         i_coord_second,
    input  wire                           i_cfg_we,
    input  wire  [2:0]                    i_cfg_idx,
    input  wire  [COORD_BITS-1:0]         i_cfg_data,
    output logic                          o_valid,
    output logic [til_pkg::TILE_BITS-1:0] o_tile_number,
    output logic [1:0]                    o_status
);

    localparam bit TWO = (DIMS >= 2);
    localparam int CW  = COORD_BITS;
    localparam int DW  = COORD_BITS + 2;   // dividend / quotient width
    localparam int RW  = COORD_BITS + 1;   // partial remainder width
    localparam int NL  = til_pkg::NLANES;
    localparam int SL  = DW / 2;
    localparam int SH  = DW - SL;
    localparam int TB  = til_pkg::TILE_BITS;

    // Configuration registers
    logic [CW-1:0] r_lo0, r_hi0, r_ext0, r_lo1, r_hi1, r_ext1;
    logic          r_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo0   <= '0;
            r_hi0   <= '1;
            r_ext0  <= '0;
            r_lo1   <= '0;
            r_hi1   <= '1;
            r_ext1  <= '0;
            r_order <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                til_pkg::REG_FIRST_LOW:     r_lo0   <= i_cfg_data;
                til_pkg::REG_FIRST_HIGH:    r_hi0   <= i_cfg_data;
                til_pkg::REG_FIRST_EXTENT:  r_ext0  <= i_cfg_data;
                til_pkg::REG_SECOND_LOW:    r_lo1   <= i_cfg_data;
                til_pkg::REG_SECOND_HIGH:   r_hi1   <= i_cfg_data;
                til_pkg::REG_SECOND_EXTENT: r_ext1  <= i_cfg_data;
                til_pkg::REG_ORDER_MODE:    r_order <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Faster dimension's bounds feed the stride lane
    logic          w_fast1;
    logic [CW-1:0] w_flo, w_fhi, w_fext;
    logic [DW-1:0] w_range, w_sdvd;
    logic          w_untiled, w_oob;

    always_comb begin
        w_fast1   = TWO && r_order;
        w_flo     = w_fast1 ? r_lo1  : r_lo0;
        w_fhi     = w_fast1 ? r_hi1  : r_hi0;
        w_fext    = w_fast1 ? r_ext1 : r_ext0;
        w_range   = DW'({1'b0, w_fhi}) - DW'({1'b0, w_flo}) + DW'(1);
        w_untiled = (r_ext0 == '0) || (TWO && (r_ext1 == '0));
        w_oob     = (i_coord_first < r_lo0) || (i_coord_first > r_hi0) ||
                    (TWO && ((i_coord_second < r_lo1) || (i_coord_second > r_hi1)));
    end

    // Ceiling numerator for the stride, registered ahead of the dividers
    always_comb begin
        w_sdvd = w_range + DW'(w_fext) - DW'(1);
    end

    // Divider pipeline: index 0 is the input stage, index DW the last step
    logic [RW-1:0] r_rem [NL][DW+1];
    logic [DW-1:0] r_quo [NL][DW+1];
    logic [RW-1:0] n_rem [NL][DW+1];
    logic [DW-1:0] n_quo [NL][DW+1];
    logic          r_vld [DW+1];
    logic [1:0]    r_sts [DW+1];
    logic          r_ord [DW+1];
    logic [RW-1:0] w_div [NL];
    logic [RW-1:0] w_trial;

    always_comb begin
        w_div[til_pkg::LANE_C0]  = RW'({1'b0, r_ext0});
        w_div[til_pkg::LANE_C1]  = RW'({1'b0, r_ext1});
        w_div[til_pkg::LANE_STR] = RW'({1'b0, w_fext});
    end

    // Entry values for the input stage
    always_comb begin
        w_trial = '0;
        for (int l = 0; l < NL; l++) begin
            n_rem[l][0] = '0;
        end
        n_quo[til_pkg::LANE_C0][0]  = DW'(i_coord_first);
        n_quo[til_pkg::LANE_C1][0]  = DW'(i_coord_second);
        n_quo[til_pkg::LANE_STR][0] = w_sdvd;
        // One restoring step per stage and lane
        for (int l = 0; l < NL; l++) begin
            for (int s = 0; s < DW; s++) begin
                w_trial = {r_rem[l][s][RW-2:0], r_quo[l][s][DW-1]};
                if (w_trial >= w_div[l]) begin
                    n_rem[l][s+1] = w_trial - w_div[l];
                    n_quo[l][s+1] = {r_quo[l][s][DW-2:0], 1'b1};
                end else begin
                    n_rem[l][s+1] = w_trial;
                    n_quo[l][s+1] = {r_quo[l][s][DW-2:0], 1'b0};
                end
            end
        end
    end

    // Advance payload through the divider stages
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            for (int s = 0; s <= DW; s++) begin
                r_rem[l][s] <= n_rem[l][s];
                r_quo[l][s] <= n_quo[l][s];
            end
        end
        r_sts[0] <= w_untiled ? til_pkg::ST_UNTILED :
                    (w_oob ? til_pkg::ST_OOB : til_pkg::ST_OK);
        r_ord[0] <= w_fast1;
        for (int s = 0; s < DW; s++) begin
            r_sts[s+1] <= r_sts[s];
            r_ord[s+1] <= r_ord[s];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DW; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start;
            for (int s = 0; s < DW; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    // Split the stride product into two partial products
    logic [CW-1:0]    w_p0, w_p1, w_fastp, w_slowp;
    logic [DW-1:0]    w_stride;
    logic [CW+SL-1:0] r_pp_lo;
    logic [CW+SH-1:0] r_pp_hi;
    logic [CW-1:0]    r_fastp;
    logic             r_mvld;
    logic [1:0]       r_msts;

    always_comb begin
        w_p0     = r_quo[til_pkg::LANE_C0][DW][CW-1:0];
        w_p1     = r_quo[til_pkg::LANE_C1][DW][CW-1:0];
        w_stride = r_quo[til_pkg::LANE_STR][DW];
        w_fastp  = r_ord[DW] ? w_p1 : w_p0;
        w_slowp  = TWO ? (r_ord[DW] ? w_p0 : w_p1) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_pp_lo <= (CW+SL)'(w_slowp) * (CW+SL)'(w_stride[SL-1:0]);
        r_pp_hi <= (CW+SH)'(w_slowp) * (CW+SH)'(w_stride[DW-1:SL]);
        r_fastp <= w_fastp;
        r_msts  <= r_sts[DW];
    end

    // Sum partial products, zero the tile when status is not ok
    logic [TB-1:0] w_tile;

    always_comb begin
        w_tile = TB'(r_fastp) + TB'(r_pp_lo) + (TB'(r_pp_hi) << SL);
    end

    always_ff @(posedge i_clk) begin
        o_tile_number <= (r_msts == til_pkg::ST_OK) ? w_tile : '0;
        o_status      <= r_msts;
    end

    // Hold the output strobe under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_mvld  <= r_vld[DW];
            o_valid <= r_mvld;
        end
    end

endmodule
`default_nettype wire

[bench/tile_index_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module tile_index_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    input  wire        busy,
    input  wire [31:0] i_coord_first,
    input  wire [31:0] i_coord_second,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [31:0] i_cfg_data,
    input  wire        o_valid,
    input  wire [63:0] o_tile_number,
    input  wire [1:0]  o_status,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [63:0]      tile;
        til_pkg::t_status status;
    } t_tile_result;

    logic [31:0] lo0, hi0, ext0, lo1, hi1, ext1;
    logic        order;
    t_tile_result tiles_due[$];

    assign o_pending = tiles_due.size();

    // Count of tiles along one dimension, rounded up
    function automatic logic [63:0] tiles_across(logic [31:0] lo, logic [31:0] hi,
                                                 logic [31:0] ext);
        logic [63:0] span;
        if (ext == 0 || hi < lo) return 64'd0;
        span = {32'd0, hi} - {32'd0, lo} + 64'd1;
        return (span + {32'd0, ext} - 64'd1) / {32'd0, ext};
    endfunction

    function automatic t_tile_result locate_tile(logic [31:0] c0, logic [31:0] c1);
        t_tile_result r;
        logic [63:0] p0, p1;
        r.tile = 64'd0;
        if (ext0 == 0 || ext1 == 0) begin
            r.status = til_pkg::ST_UNTILED;
        end else if (c0 < lo0 || c0 > hi0 || c1 < lo1 || c1 > hi1) begin
            r.status = til_pkg::ST_OOB;
        end else begin
            p0 = {32'd0, c0 / ext0};
            p1 = {32'd0, c1 / ext1};
            r.status = til_pkg::ST_OK;
            if (order == 1'b0) r.tile = p0 + p1 * tiles_across(lo0, hi0, ext0);
            else r.tile = p1 + p0 * tiles_across(lo1, hi1, ext1);
        end
        return r;
    endfunction

    // Track config, predict on each request, compare each result
    always @(posedge i_clk) begin
        t_tile_result want;
        if (!i_rst_n) begin
            lo0 <= 0; hi0 <= '1; ext0 <= 0;
            lo1 <= 0; hi1 <= '1; ext1 <= 0;
            order <= 1'b0;
            o_fail_count <= 0;
            tiles_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    til_pkg::REG_FIRST_LOW:     lo0 <= i_cfg_data;
                    til_pkg::REG_FIRST_HIGH:    hi0 <= i_cfg_data;
                    til_pkg::REG_FIRST_EXTENT:  ext0 <= i_cfg_data;
                    til_pkg::REG_SECOND_LOW:    lo1 <= i_cfg_data;
                    til_pkg::REG_SECOND_HIGH:   hi1 <= i_cfg_data;
                    til_pkg::REG_SECOND_EXTENT: ext1 <= i_cfg_data;
                    til_pkg::REG_ORDER_MODE:    order <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_valid) begin
                if (tiles_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result tile=%0d status=%0d",
                                 o_tile_number, o_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = tiles_due.pop_front();
                    if (o_tile_number !== want.tile || o_status !== want.status) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected tile=%0d status=%0d, got tile=%0d status=%0d",
                                     want.tile, want.status, o_tile_number, o_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                tiles_due = {tiles_due, locate_tile(i_coord_first, i_coord_second)};
        end
    end
endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam int LATENCY = 37;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_coord_first = '0, i_coord_second = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic [63:0] o_tile_number;
    logic [1:0]  o_status;
    int          fail_count, pending;
    longint      cycle_count = 0;

    tile_index_linearizer #(.DIMS(2), .COORD_BITS(32)) DUT (.*);

    tile_index_checker checker_inst (
        .i_clk, .i_rst_n, .start, .busy, .i_coord_first, .i_coord_second,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_valid, .o_tile_number, .o_status,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL tile_index_linearizer");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every result is back, then let the pipe drain
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic send_request(logic [31:0] c0, logic [31:0] c1, bit gaps);
        int wait_cycles;
        wait_cycles = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18)) : 0;
        if (wait_cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (wait_cycles - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1; i_coord_first <= c0; i_coord_second <= c1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic setup_domain(logic [31:0] l0, logic [31:0] h0, logic [31:0] e0,
                                logic [31:0] l1, logic [31:0] h1, logic [31:0] e1,
                                logic om);
        write_reg(til_pkg::REG_FIRST_LOW, l0);
        write_reg(til_pkg::REG_FIRST_HIGH, h0);
        write_reg(til_pkg::REG_FIRST_EXTENT, e0);
        write_reg(til_pkg::REG_SECOND_LOW, l1);
        write_reg(til_pkg::REG_SECOND_HIGH, h1);
        write_reg(til_pkg::REG_SECOND_EXTENT, e1);
        write_reg(til_pkg::REG_ORDER_MODE, {31'd0, om});
    endtask

    initial begin
        logic [31:0] l0, h0, e0, l1, h1, e1, c0, c1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: untiled at reset values
        send_request(32'd0, 32'hFFFF_FFFF, 0);
        send_request(32'hFFFF_FFFF, 32'd0, 0);
        drain();
        // Full domain, extent 1, both orders
        setup_domain(0, '1, 1, 0, '1, 1, 0);
        write_reg(3'd7, 32'h1234_5678);
        send_request('1, '1, 0);
        send_request(0, 0, 0);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 0);
        drain();
        write_reg(til_pkg::REG_ORDER_MODE, 1);
        send_request('1, '1, 0);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 0);
        drain();
        // Out of domain edges, extent above range
        setup_domain(10, 20, 100, 5, 50, 7, 0);
        send_request(9, 5, 0);
        send_request(21, 5, 0);
        send_request(10, 4, 0);
        send_request(10, 51, 0);
        send_request(20, 50, 0);
        send_request(10, 5, 0);
        drain();
        // Empty domain; one extent zero; huge extent
        setup_domain(30, 20, 3, 0, 100, 0, 1);
        send_request(25, 50, 0);
        drain();
        write_reg(til_pkg::REG_SECOND_EXTENT, 32'hFFFF_FFFF);
        send_request(25, 50, 0);
        drain();

        // Random phases
        for (int ph = 0; ph < 40; ph++) begin
            l0 = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(0, 200);
            h0 = $urandom_range(0, 3) == 0 ? rand_word() : l0 + $urandom_range(0, 5000);
            e0 = $urandom_range(0, 9) == 0 ? 32'd0 :
                 ($urandom_range(0, 4) == 0 ? rand_word() : $urandom_range(1, 64));
            l1 = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(0, 200);
            h1 = $urandom_range(0, 3) == 0 ? rand_word() : l1 + $urandom_range(0, 5000);
            e1 = $urandom_range(0, 9) == 0 ? 32'd0 :
                 ($urandom_range(0, 4) == 0 ? rand_word() : $urandom_range(1, 64));
            setup_domain(l0, h0, e0, l1, h1, e1, $urandom_range(0, 1));
            for (int n = 0; n < 25; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    c0 = rand_word(); c1 = rand_word();
                end else begin
                    c0 = (h0 >= l0) ? l0 + $urandom_range(0, h0 - l0) : rand_word();
                    c1 = (h1 >= l1) ? l1 + $urandom_range(0, h1 - l1) : rand_word();
                end
                send_request(c0, c1, ph % 4 != 0);
            end
            drain();
        end

        // Final settle then verdict
        drain();
        if (fail_count == 0) $display("PASS tile_index_linearizer");
        else $display("FAIL tile_index_linearizer");
        $finish;
    end
endmodule
`default_nettype wire
